// File: sv/lcfs_pkg.sv
// ============================================================================
// lcfs_pkg
// Shared types, constants and helpers for the line/column/field selector.
// ============================================================================
package lcfs_pkg;

    // Width of the first-token fill count. It holds any token buffer depth
    // from 1 to 63.
    localparam int CNT_W             = 6;
    localparam int TOKEN_DEPTH_DEF   = 48;
    localparam int CMD_QUEUE_DEPTH   = 4;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int NUM_RANGES        = 4;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [7:0]  CHAR_LF   = 8'h0A;
    localparam logic [7:0]  CHAR_NUL  = 8'h00;
    localparam logic [7:0]  CHAR_TAB  = 8'h09;
    localparam logic [31:0] RANGE_RESET = 32'h0001_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DELIMITER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NUL_TERM   = 3'd7;

    typedef logic [NUM_RANGES-1:0][31:0] t_ranges;

    typedef struct packed {
        t_ranges    ranges;
        logic       field_mode;
        logic [7:0] delimiter;
        logic       suppress_undelimited;
        logic       nul_terminator;
    } t_cfg;

    // One unit of work for the back end. A store writes byte0 into the
    // token memory at cnt. Otherwise the back end emits the first cnt
    // stored bytes, then nbytes of byte0 and byte1, marking the final one.
    typedef struct packed {
        logic             store;
        logic [CNT_W-1:0] cnt;
        logic [1:0]       nbytes;
        logic [7:0]       byte0;
        logic [7:0]       byte1;
        logic             ovf;
    } t_cmd;

    // True when pos falls inside any of the inclusive ranges.
    function automatic logic selected(input t_ranges r, input logic [15:0] pos);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_RANGES; i++) begin
            if (pos >= r[i][31:16] && pos <= r[i][15:0]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

// File: sv/line_column_field_selector.sv
// ============================================================================
// line_column_field_selector
// Byte and field selector for newline-ended text lines.
// ============================================================================
// The block takes one text byte per request and returns the selected parts
// of each line as a stream of result requests. A front end keeps the line
// state and accepts one input request every cycle while its four-entry
// command queue has room; each input becomes at most one command. The back
// end drains that queue through an output register at one result per cycle
// while results are taken, and pops a command with its last result (a
// field-mode line flushing its buffered first token gives up to
// TOKEN_DEPTH plus one bytes at once). A command that stores a first-token
// byte gives no result and does not wait for the result side. Input stalls
// only when a long flush or a stalled result side fills the command queue.
// The token memory needs no clearing after reset: only entries already
// written on the current line are read back. Configuration writes take
// effect on the next cycle and must be made while the block is idle.
// ============================================================================
module line_column_field_selector
    import lcfs_pkg::*;
#(
    parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input side
    input  logic                  push,
    output logic                  full,
    input  logic                  i_action,
    input  logic [7:0]            i_in_byte,
    // Result side
    output logic                  empty,
    input  logic                  pop,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_run,
    output logic                  o_token_overflow,
    // Configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic accept;
    logic cmd_push;
    t_cmd cmd_in;
    t_cmd cmd_head;
    logic cmd_valid;
    logic cmd_pop;

    // Configuration registers. Unused high bits of narrow registers are
    // dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ranges               <= {NUM_RANGES{RANGE_RESET}};
            r_cfg.field_mode           <= 1'b0;
            r_cfg.delimiter            <= CHAR_TAB;
            r_cfg.suppress_undelimited <= 1'b0;
            r_cfg.nul_terminator       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RANGE_0:    r_cfg.ranges[0]            <= i_cfg_data;
                REG_RANGE_1:    r_cfg.ranges[1]            <= i_cfg_data;
                REG_RANGE_2:    r_cfg.ranges[2]            <= i_cfg_data;
                REG_RANGE_3:    r_cfg.ranges[3]            <= i_cfg_data;
                REG_FIELD_MODE: r_cfg.field_mode           <= i_cfg_data[0];
                REG_DELIMITER:  r_cfg.delimiter            <= i_cfg_data[7:0];
                REG_SUPPRESS:   r_cfg.suppress_undelimited <= i_cfg_data[0];
                REG_NUL_TERM:   r_cfg.nul_terminator       <= i_cfg_data[0];
            endcase
        end
    end

    assign accept = push && !full;

    // The front end tracks the open line and decides what each byte causes.
    lcfs_front #(
        .TOKEN_DEPTH (TOKEN_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_action),
        .i_byte     (i_in_byte),
        .i_cfg      (r_cfg),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    // The command queue lets input keep flowing while results are stalled
    // or a buffered token is being replayed.
    lcfs_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head),
        .o_valid (cmd_valid),
        .o_full  (full)
    );

    // The back end owns the token memory and the output register.
    lcfs_back #(
        .TOKEN_DEPTH (TOKEN_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last_of_run),
        .o_ovf       (o_token_overflow)
    );

endmodule

// File: sv/lcfs_fifo.sv
// ============================================================================
// lcfs_fifo
// Small synchronous queue between the front end and the back end.
// ============================================================================
module lcfs_fifo
    import lcfs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_valid,
    output logic             o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr_ptr;
    logic [AW:0]      r_rd_ptr;

    assign o_valid = (r_wr_ptr != r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) &&
                     (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign o_data  = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

endmodule

// File: sv/lcfs_front.sv
// ============================================================================
// lcfs_front
// Line state tracker: classifies each input byte and issues back-end work.
// ============================================================================
module lcfs_front
    import lcfs_pkg::*;
#(
    parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_action,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    logic [CNT_W-1:0] r_stored, n_stored;
    logic [15:0]      r_pos, n_pos;
    logic [15:0]      r_field, n_field;
    logic             r_inside, n_inside;
    logic             r_delim_seen, n_delim_seen;
    logic             r_out_started, n_out_started;
    logic             r_after_nul, n_after_nul;
    logic             r_line_open, n_line_open;
    logic             r_ovf, n_ovf;

    always_comb begin
        logic        do_close;
        logic        began;
        logic [15:0] field_nx;
        logic [7:0]  term;

        n_stored      = r_stored;
        n_pos         = r_pos;
        n_field       = r_field;
        n_inside      = r_inside;
        n_delim_seen  = r_delim_seen;
        n_out_started = r_out_started;
        n_after_nul   = r_after_nul;
        n_line_open   = r_line_open;
        n_ovf         = r_ovf;
        o_cmd_push    = 1'b0;
        o_cmd         = '0;
        o_cmd.ovf     = i_cfg.field_mode && r_ovf;
        do_close      = 1'b0;
        term          = i_cfg.nul_terminator ? CHAR_NUL : CHAR_LF;

        began    = !r_inside;
        field_nx = (began && r_field != COUNT_MAX) ? r_field + 16'd1 : r_field;

        if (i_accept) begin
            if (i_action) begin
                do_close = r_line_open;
            end else begin
                n_line_open = 1'b1;
                if (i_byte == CHAR_LF) begin
                    do_close = 1'b1;
                end else if (r_after_nul) begin
                    n_after_nul = 1'b1;
                end else if (i_byte == CHAR_NUL) begin
                    n_after_nul = 1'b1;
                end else if (i_cfg.field_mode) begin
                    if (i_byte == i_cfg.delimiter) begin
                        if (!r_delim_seen) begin
                            n_delim_seen = 1'b1;
                            if (r_stored != '0 && selected(i_cfg.ranges, 16'd1)) begin
                                o_cmd_push    = 1'b1;
                                o_cmd.cnt     = r_stored;
                                n_out_started = 1'b1;
                            end
                        end
                        n_inside = 1'b0;
                    end else begin
                        n_inside = 1'b1;
                        n_field  = field_nx;
                        if (!r_delim_seen) begin
                            if (r_stored < CNT_W'(TOKEN_DEPTH)) begin
                                o_cmd_push  = 1'b1;
                                o_cmd.store = 1'b1;
                                o_cmd.cnt   = r_stored;
                                o_cmd.byte0 = i_byte;
                                n_stored    = r_stored + 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end else if (selected(i_cfg.ranges, field_nx)) begin
                            o_cmd_push = 1'b1;
                            if (began && r_out_started) begin
                                o_cmd.nbytes = 2'd2;
                                o_cmd.byte0  = i_cfg.delimiter;
                                o_cmd.byte1  = i_byte;
                            end else begin
                                o_cmd.nbytes = 2'd1;
                                o_cmd.byte0  = i_byte;
                            end
                            n_out_started = 1'b1;
                        end
                    end
                end else begin
                    if (selected(i_cfg.ranges, r_pos)) begin
                        o_cmd_push   = 1'b1;
                        o_cmd.nbytes = 2'd1;
                        o_cmd.byte0  = i_byte;
                    end
                    if (r_pos != COUNT_MAX) begin
                        n_pos = r_pos + 16'd1;
                    end
                end
            end

            if (do_close) begin
                o_cmd.nbytes = 2'd1;
                o_cmd.byte0  = term;
                if (i_cfg.field_mode) begin
                    if (!r_delim_seen) begin
                        o_cmd_push = !i_cfg.suppress_undelimited;
                        o_cmd.cnt  = r_stored;
                    end else begin
                        o_cmd_push = r_out_started;
                    end
                end else begin
                    o_cmd_push = 1'b1;
                end
                n_stored      = '0;
                n_pos         = 16'd1;
                n_field       = '0;
                n_inside      = 1'b0;
                n_delim_seen  = 1'b0;
                n_out_started = 1'b0;
                n_after_nul   = 1'b0;
                n_line_open   = 1'b0;
                n_ovf         = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored      <= '0;
            r_pos         <= 16'd1;
            r_field       <= '0;
            r_inside      <= 1'b0;
            r_delim_seen  <= 1'b0;
            r_out_started <= 1'b0;
            r_after_nul   <= 1'b0;
            r_line_open   <= 1'b0;
            r_ovf         <= 1'b0;
        end else begin
            r_stored      <= n_stored;
            r_pos         <= n_pos;
            r_field       <= n_field;
            r_inside      <= n_inside;
            r_delim_seen  <= n_delim_seen;
            r_out_started <= n_out_started;
            r_after_nul   <= n_after_nul;
            r_line_open   <= n_line_open;
            r_ovf         <= n_ovf;
        end
    end

`ifndef SYNTH
    // Token stores always land inside the buffer.
    a_store_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push && o_cmd.store |-> o_cmd.cnt < CNT_W'(TOKEN_DEPTH))
        else $error("token store beyond buffer depth");

    // Dropping token bytes needs a full buffer on an undelimited prefix.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_stored == CNT_W'(TOKEN_DEPTH) && r_line_open)
        else $error("overflow flagged with room left in token buffer");
`endif

endmodule

// File: sv/lcfs_back.sv
// ============================================================================
// lcfs_back
// Output sequencer: holds the first-token memory and emits result bytes.
// ============================================================================
module lcfs_back
    import lcfs_pkg::*;
#(
    parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_last,
    output logic       o_ovf
);

    localparam int AW = (TOKEN_DEPTH > 1) ? $clog2(TOKEN_DEPTH) : 1;

    logic [7:0]     r_mem [TOKEN_DEPTH];
    logic [CNT_W:0] r_elem;
    logic [CNT_W:0] total;
    logic           in_flush;
    logic           is_last;
    logic           issue;
    logic           mem_wr;
    logic           r_hold_valid;
    logic [7:0]     r_hold_data;
    logic           r_hold_last;
    logic           r_hold_ovf;

    assign total    = {1'b0, i_cmd.cnt} + {{(CNT_W-1){1'b0}}, i_cmd.nbytes};
    assign in_flush = r_elem < {1'b0, i_cmd.cnt};
    assign is_last  = (r_elem == total - 1'b1);
    assign mem_wr   = i_cmd_valid && i_cmd.store;
    assign issue    = i_cmd_valid && !i_cmd.store && (!r_hold_valid || i_pop);
    assign o_cmd_pop = mem_wr || (issue && is_last);

    assign o_empty    = !r_hold_valid;
    assign o_out_byte = r_hold_data;
    assign o_last     = r_hold_last;
    assign o_ovf      = r_hold_ovf;

    // Token memory: one write port for stores, one registered read port
    // feeding the output register.
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[i_cmd.cnt[AW-1:0]] <= i_cmd.byte0;
        end
        if (issue) begin
            if (in_flush) begin
                r_hold_data <= r_mem[r_elem[AW-1:0]];
            end else if (r_elem == {1'b0, i_cmd.cnt}) begin
                r_hold_data <= i_cmd.byte0;
            end else begin
                r_hold_data <= i_cmd.byte1;
            end
            r_hold_last <= is_last;
            r_hold_ovf  <= i_cmd.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elem       <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_elem <= is_last ? '0 : r_elem + 1'b1;
            end
            if (issue) begin
                r_hold_valid <= 1'b1;
            end else if (i_pop) begin
                r_hold_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_elem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !i_cmd.store |-> r_elem < total)
        else $error("element counter ran past the command");

    a_elem_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd_valid |-> r_elem == '0)
        else $error("element counter left nonzero with no command");

    a_no_empty_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !i_cmd.store |-> total != '0)
        else $error("output command without any result");
`endif

endmodule

// File: bench/lcfs_bench_pkg.sv
// ============================================================================
// lcfs_bench_pkg
// Scoreboard for the line/column/field selector bench. It keeps its own copy
// of the selector's settings and line state, predicts the bytes that each
// accepted request must produce, and checks returned results in order.
// ============================================================================
package lcfs_bench_pkg;

    import lcfs_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       token_overflow;
    } t_sel_result;

    class selector_scoreboard;

        // Settings as last written.
        bit [31:0]   ranges [NUM_RANGES];
        bit          field_mode;
        bit [7:0]    delimiter;
        bit          suppress_undelimited;
        bit          nul_terminator;

        // Line state.
        bit [7:0]    token_store [TOKEN_DEPTH_DEF];
        int unsigned token_count;
        bit [15:0]   position;
        bit [15:0]   field_num;
        bit          in_token;
        bit          delim_seen;
        bit          out_started;
        bit          after_nul;
        bit          line_open;
        bit          overflow_seen;

        t_sel_result expected_bytes [$];
        t_sel_result step_bytes [$];
        int unsigned mismatches;

        function new();
            for (int i = 0; i < NUM_RANGES; i++) begin
                ranges[i] = RANGE_RESET;
            end
            field_mode           = 1'b0;
            delimiter            = CHAR_TAB;
            suppress_undelimited = 1'b0;
            nul_terminator       = 1'b0;
            mismatches           = 0;
            clear_line();
        endfunction

        function bit range_hit(bit [15:0] pos);
            for (int i = 0; i < NUM_RANGES; i++) begin
                if (pos >= ranges[i][31:16] && pos <= ranges[i][15:0]) begin
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void push_byte(bit [7:0] b);
            step_bytes.push_back('{out_byte: b, last_of_run: 1'b0,
                                   token_overflow: field_mode && overflow_seen});
        endfunction

        function void flush_token();
            for (int i = 0; i < token_count; i++) begin
                push_byte(token_store[i]);
            end
        endfunction

        function void clear_line();
            token_count   = 0;
            position      = 16'd1;
            field_num     = 16'd0;
            in_token      = 1'b0;
            delim_seen    = 1'b0;
            out_started   = 1'b0;
            after_nul     = 1'b0;
            line_open     = 1'b0;
            overflow_seen = 1'b0;
        endfunction

        function void close_line();
            bit [7:0] term;
            term = nul_terminator ? CHAR_NUL : CHAR_LF;
            if (!field_mode) begin
                push_byte(term);
            end else if (!delim_seen) begin
                // A line without any delimiter is passed, up to the buffer depth, unless suppressed.
                if (!suppress_undelimited) begin
                    flush_token();
                    push_byte(term);
                end
            end else if (out_started) begin
                push_byte(term);
            end
            clear_line();
        endfunction

        function void field_step(bit [7:0] b);
            bit began;
            began = 1'b0;
            if (b == delimiter) begin
                if (!delim_seen) begin
                    delim_seen = 1'b1;
                    if (token_count > 0 && range_hit(16'd1)) begin
                        flush_token();
                        out_started = 1'b1;
                    end
                end
                in_token = 1'b0;
                return;
            end
            if (!in_token) begin
                in_token = 1'b1;
                began    = 1'b1;
                if (field_num != COUNT_MAX) begin
                    field_num++;
                end
            end
            if (!delim_seen) begin
                if (token_count < TOKEN_DEPTH_DEF) begin
                    token_store[token_count] = b;
                    token_count++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end else if (range_hit(field_num)) begin
                if (began && out_started) begin
                    push_byte(delimiter);
                end
                push_byte(b);
                out_started = 1'b1;
            end
        endfunction

        function void write_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
            case (idx) inside
                REG_RANGE_0, REG_RANGE_1, REG_RANGE_2, REG_RANGE_3: begin
                    ranges[idx[1:0]] = data;
                end
                REG_FIELD_MODE: field_mode           = data[0];
                REG_DELIMITER:  delimiter            = data[7:0];
                REG_SUPPRESS:   suppress_undelimited = data[0];
                REG_NUL_TERM:   nul_terminator       = data[0];
                default: ;
            endcase
        endfunction

        // Works out the results of one accepted input request.
        function void note_request(bit action, bit [7:0] b);
            t_sel_result tail;
            step_bytes.delete();
            if (action) begin
                if (line_open) begin
                    close_line();
                end
            end else begin
                line_open = 1'b1;
                if (b == CHAR_LF) begin
                    close_line();
                end else if (after_nul) begin
                    // Everything after a NUL is dropped until the line closes.
                end else if (b == CHAR_NUL) begin
                    after_nul = 1'b1;
                end else if (field_mode) begin
                    field_step(b);
                end else begin
                    if (range_hit(position)) begin
                        push_byte(b);
                    end
                    if (position != COUNT_MAX) begin
                        position++;
                    end
                end
            end
            if (step_bytes.size() > 0) begin
                tail = step_bytes.pop_back();
                tail.last_of_run = 1'b1;
                step_bytes.push_back(tail);
            end
            foreach (step_bytes[i]) begin
                expected_bytes.push_back(step_bytes[i]);
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void check_result(bit [7:0] b, bit last, bit ovf);
            t_sel_result want;
            if (expected_bytes.size() == 0) begin
                flag($sformatf("unexpected result: byte %02h last %0d ovf %0d", b, last, ovf));
                return;
            end
            want = expected_bytes.pop_front();
            if (want.out_byte !== b || want.last_of_run !== last
                    || want.token_overflow !== ovf) begin
                flag($sformatf("mismatch: expected byte %02h last %0d ovf %0d, got %02h %0d %0d",
                               want.out_byte, want.last_of_run, want.token_overflow,
                               b, last, ovf));
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

    endclass

endpackage

// File: bench/tb.sv
// ============================================================================
// tb
// Self-checking bench for the line/column/field selector.
// ============================================================================
// Text bytes are pushed into the selector through its queue-style input and
// the selected bytes are popped from its result side. A scoreboard predicts
// every result from its own copy of the settings and line state and checks
// results in order. A short directed part covers reset behavior, NUL inside
// a line, end of stream, leading and repeated delimiters, a settings change
// in mid-line and suppressed or empty lines. Random phases follow under
// several settings and idling patterns, with some lines long enough to
// overflow the first-token buffer.
// ============================================================================
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lcfs_pkg::*;
    import lcfs_bench_pkg::*;

    // Cycles to let the block finish commands that produce no result (stores
    // of first-token bytes) before the settings are changed.
    localparam int SETTLE_CYCLES = 24;
    // Cycles without any accepted request before the run is declared hung.
    localparam int HANG_LIMIT    = 5000;
    localparam int PHASE_ITEMS   = 48;
    localparam int NUM_PHASES    = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  i_action = 1'b0;
    logic [7:0]            i_in_byte = 8'h00;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_last_of_run;
    logic                  o_token_overflow;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    selector_scoreboard sb;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned sent_count = 0;
    int unsigned quiet_cycles = 0;

    line_column_field_selector dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_action         (i_action),
        .i_in_byte        (i_in_byte),
        .empty            (empty),
        .pop              (pop),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .o_token_overflow (o_token_overflow),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // The receiver decides at each falling edge whether it takes a result at
    // the next rising edge.
    initial begin
        forever begin
            @(negedge i_clk);
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Results are sampled at the rising edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_out_byte, o_last_of_run, o_token_overflow);
        end
    end

    // Hang detection: any accepted request on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= HANG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Sends one input request. It is entered and left just after a falling
    // edge; push stays high on return so back-to-back requests need no gap.
    task automatic send_request(input bit action, input bit [7:0] b);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push      <= 1'b1;
        i_action  <= action;
        i_in_byte <= b;
        while (!taken) begin
            @(posedge i_clk);
            if (!full) begin
                taken = 1'b1;
                sb.note_request(action, b);
            end
        end
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_request(1'b0, s[i]);
        end
    endtask

    // Stops the sender until every predicted result has been returned. It
    // always waits for a falling edge, so a following request never shares
    // a time step with the lowering of push.
    task automatic wait_drained();
        push <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (sb.pending() != 0);
    endtask

    task automatic write_reg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_register(idx, data);
        @(negedge i_clk);
    endtask

    // Writes every register once the block has gone quiet.
    task automatic configure(input bit fm, input bit [7:0] dl, input bit sup, input bit nt,
                             input bit [31:0] r0, input bit [31:0] r1,
                             input bit [31:0] r2, input bit [31:0] r3);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(REG_RANGE_0, r0);
        write_reg(REG_RANGE_1, r1);
        write_reg(REG_RANGE_2, r2);
        write_reg(REG_RANGE_3, r3);
        write_reg(REG_FIELD_MODE, {31'd0, fm});
        write_reg(REG_DELIMITER, {24'd0, dl});
        write_reg(REG_SUPPRESS, {31'd0, sup});
        write_reg(REG_NUL_TERM, {31'd0, nt});
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Text bytes are mostly letters and delimiters, with some NULs and a few
    // arbitrary bytes so that every bit of the byte port toggles.
    function automatic logic [7:0] pick_text_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 18) return sb.delimiter;
        if (r < 20) return CHAR_NUL;
        if (r < 24) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Ranges are mostly short windows over the first few positions, with the
    // extremes mixed in: disabled, everything, only the top position, open end.
    function automatic logic [31:0] pick_range();
        logic [15:0] lo;
        lo = 16'($urandom_range(0, 8));
        case ($urandom_range(0, 9))
            0:       return 32'hFFFF_0000;
            1:       return 32'h0000_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return {lo, 16'hFFFF};
            4:       return $urandom;
            default: return {lo, lo + 16'($urandom_range(0, 6))};
        endcase
    endfunction

    // One line of random text. Most lines end in a newline; some are closed
    // by end of stream, some run on into the next line, and now and then an
    // end of stream arrives with no line open.
    task automatic send_random_line();
        int unsigned len;
        int unsigned r;
        r   = $urandom_range(0, 99);
        len = (r < 8) ? $urandom_range(40, 60) : $urandom_range(0, 10);
        for (int unsigned k = 0; k < len; k++) begin
            send_request(1'b0, pick_text_byte());
        end
        r = $urandom_range(0, 99);
        if (r < 88) begin
            send_request(1'b0, CHAR_LF);
        end else if (r < 95) begin
            send_request(1'b1, 8'($urandom));
        end
        if ($urandom_range(0, 99) < 4) begin
            send_request(1'b1, 8'($urandom));
        end
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned start;
        start = sent_count;
        while (sent_count - start < n) begin
            send_random_line();
        end
    endtask

    initial begin
        sb = new();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- Directed part ----
        send_idle_pct = 10;
        recv_idle_pct = 30;
        // Reset settings select no position: a byte-mode line gives only its
        // newline, and an end of stream with no open line gives nothing.
        send_text("a");
        send_request(1'b0, CHAR_LF);
        send_request(1'b1, 8'hA5);

        // Byte mode with NUL termination; a NUL in mid-line hides the rest.
        configure(1'b0, CHAR_TAB, 1'b0, 1'b1,
                  32'h0001_0001, 32'h0003_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF);
        send_text("abc");
        send_request(1'b0, CHAR_NUL);
        send_text("d");
        send_request(1'b0, CHAR_LF);

        // Field mode: leading and doubled delimiters are empty tokens and are
        // skipped; the open line is closed by end of stream.
        configure(1'b1, 8'h2C, 1'b0, 1'b0,
                  32'h0001_0001, 32'h0003_0003, 32'hFFFF_0000, 32'hFFFF_0000);
        send_text(",ab,,c,d");
        send_request(1'b1, 8'h00);

        // The settings change halfway through a line; the line state stays.
        // The line turns out delimited with nothing selected, so it is silent.
        send_text("pq");
        configure(1'b1, 8'h2C, 1'b1, 1'b0,
                  32'h0004_0004, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
        send_text(",r");
        send_request(1'b0, CHAR_LF);
        // An undelimited line is dropped while suppression is on.
        send_text("st");
        send_request(1'b0, CHAR_LF);

        // ---- Random phases ----
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p / 2)
                0: begin send_idle_pct = 23; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 23; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            case (p)
                0: configure(1'b0, 8'h2C, 1'b0, 1'b0,
                             pick_range(), pick_range(), pick_range(), pick_range());
                1: configure(1'b1, 8'h2C, 1'b0, 1'b1,
                             pick_range(), pick_range(), pick_range(), pick_range());
                2: configure(1'b1, 8'hFF, 1'b1, 1'b0,
                             pick_range(), pick_range(), pick_range(), pick_range());
                3: configure(1'b0, 8'h01, 1'b0, 1'b1,
                             32'h0000_FFFF, 32'hFFFF_0000, pick_range(), pick_range());
                // A newline delimiter can never match, so every line is undelimited.
                4: configure(1'b1, CHAR_LF, 1'b0, 1'b0,
                             pick_range(), pick_range(), pick_range(), pick_range());
                default: configure(1'b1, 8'h01, 1'($urandom), 1'($urandom),
                                   pick_range(), pick_range(), pick_range(), pick_range());
            endcase
            run_random(PHASE_ITEMS / 2);
            // Once, the sender holds off until the result side has caught up.
            if (p == 1) begin
                wait_drained();
            end
            run_random(PHASE_ITEMS / 2);
        end

        // ---- Wind-down ----
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0d expected results never arrived", sb.pending());
        end
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: line_column_field_selector.f
sv/lcfs_pkg.sv
sv/lcfs_fifo.sv
sv/lcfs_front.sv
sv/lcfs_back.sv
sv/line_column_field_selector.sv
bench/lcfs_bench_pkg.sv
bench/tb.sv
